### hw/rtl/ctc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the chord template classifier.
// No dependencies; ctc_lane and the top level import this package.

package ctc_pkg;

  // Defaults of the top-level parameters
  localparam int TEMPLATE_COUNT_DEF = 22;
  localparam int NOTE_RANGE_DEF     = 128;

  // Template ROM geometry
  localparam int ROM_SLOTS = 32;
  localparam int TPL_IDX_W = 5;
  localparam int PRIO_W    = 7;
  localparam int PC_N      = 12;
  localparam int PC_W      = 4;
  localparam int SCORE_W   = 12;
  localparam int CHUNK_W   = 4;   // up to 16 scan steps of 8 notes

  // Quality codes
  localparam logic [4:0] Q_UNKNOWN = 5'd0;
  localparam logic [4:0] Q_SINGLE  = 5'd1;
  localparam logic [4:0] Q_BASE    = 5'd2;
  localparam logic [4:0] Q_POWER   = 5'd23;
  localparam logic [4:0] Q_CLUSTER = 5'd24;

  // Decision stage codes
  localparam logic [2:0] DEC_EMPTY     = 3'd0;
  localparam logic [2:0] DEC_SINGLE    = 3'd1;
  localparam logic [2:0] DEC_ROOT      = 3'd2;
  localparam logic [2:0] DEC_UPPER     = 3'd3;
  localparam logic [2:0] DEC_INVERSION = 3'd4;
  localparam logic [2:0] DEC_PARTIAL   = 3'd5;
  localparam logic [2:0] DEC_POWER     = 3'd6;
  localparam logic [2:0] DEC_CLUSTER   = 3'd7;

  localparam logic [11:0] MASK_SINGLE = 12'h001;
  localparam logic [11:0] MASK_POWER  = 12'h081;

  // Interval templates, intervals above the root as a 12-bit mask
  localparam logic [11:0] TPL_MASK [ROM_SLOTS] = '{
    12'h895, 12'h495, 12'h48D, 12'h095, 12'h8D1,
    12'h891, 12'h491, 12'h489, 12'h449, 12'h249, 12'h889, 12'h4A1, 12'h511,
    12'h291, 12'h289,
    12'h091, 12'h089, 12'h049, 12'h111, 12'h0A1, 12'h085,
    12'h081,
    12'h000, 12'h000, 12'h000, 12'h000, 12'h000,
    12'h000, 12'h000, 12'h000, 12'h000, 12'h000
  };

  localparam logic [PRIO_W-1:0] TPL_PRIO [ROM_SLOTS] = '{
    7'd110, 7'd110, 7'd110, 7'd100, 7'd105,
    7'd90, 7'd90, 7'd90, 7'd95, 7'd95, 7'd85, 7'd85, 7'd85, 7'd80, 7'd80,
    7'd70, 7'd70, 7'd75, 7'd75, 7'd65, 7'd65,
    7'd40,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0
  };

  typedef logic signed [SCORE_W-1:0] score_t;

  // One template RAM word
  typedef struct packed {
    logic [11:0]       mask;
    logic [PRIO_W-1:0] prio;
  } tpl_entry_t;

  // Template stream from the RAM into the lanes
  typedef struct packed {
    logic                 clr;
    logic                 vld;
    logic [TPL_IDX_W-1:0] tidx;
    tpl_entry_t           ent;
  } sweep_t;

  // Per-item context shared by all lanes
  typedef struct packed {
    logic [11:0]     pcs;
    logic [11:0]     upper;
    logic [PC_W-1:0] sz;
    logic [PC_W-1:0] bpc;
  } ctx_t;

  // What one root lane found over the sweep
  typedef struct packed {
    logic                 xp_hit;
    logic [TPL_IDX_W-1:0] xp_t;
    logic                 xu_hit;
    logic [TPL_IDX_W-1:0] xu_t;
    logic                 pa_hit;
    logic [TPL_IDX_W-1:0] pa_t;
    score_t               pa_score;
  } lane_res_t;

  function automatic logic [PC_W-1:0] pop12(input logic [11:0] m);
    logic [PC_W-1:0] c;
    c = '0;
    for (int i = 0; i < PC_N; i++) begin
      c = c + PC_W'(m[i]);
    end
    return c;
  endfunction

  // Interval set of x seen from root r: bit i is x[(i + r) mod 12]
  function automatic logic [11:0] rot12(input logic [11:0] x, input int r);
    logic [23:0] d;
    d = {x, x};
    return d[r +: 12];
  endfunction

endpackage

### hw/rtl/ctc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the chord template classifier.
// No dependencies.

interface ctc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] notes_low;
  logic [63:0] notes_high;

  modport source (output valid, output notes_low, output notes_high, input ready);
  modport sink   (input valid, input notes_low, input notes_high, output ready);
endinterface

interface ctc_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  quality;
  logic [3:0]  root_class;
  logic [6:0]  bass_note;
  logic        is_slash;
  logic [11:0] tone_mask;
  logic [2:0]  decided_by;

  modport source (output valid, output quality, output root_class, output bass_note,
                  output is_slash, output tone_mask, output decided_by, input ready);
  modport sink   (input valid, input quality, input root_class, input bass_note,
                  input is_slash, input tone_mask, input decided_by, output ready);
endinterface

### hw/rtl/ctc_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module ctc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/ctc_lane.sv
`timescale 1ns / 1ps
// One root lane: checks the streamed templates against the pitch-class set
// seen from a fixed root. Depends on ctc_pkg.

module ctc_lane #(
  parameter int ROOT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctc_pkg::sweep_t    sweep,
  input  ctc_pkg::ctx_t      ctx,
  output ctc_pkg::lane_res_t res
);
  import ctc_pkg::*;

  logic [11:0]     rot_p;
  logic [11:0]     rot_u;
  logic [PC_W-1:0] matched;
  logic [PC_W-1:0] tsz;
  logic [PC_W-1:0] miss;
  logic            nz;
  logic            ex_p;
  logic            ex_u;
  logic            part_ok;
  logic [11:0]     p12;
  logic [11:0]     m12;
  logic [11:0]     score_u;
  score_t          score;
  lane_res_t       res_r;
  lane_res_t       res_nxt;

  // Rotations to this lane's root are fixed wiring
  assign rot_p = rot12(ctx.pcs, ROOT);
  assign rot_u = rot12(ctx.upper, ROOT);

  // Exact and partial tests against the current template
  assign nz      = |sweep.ent.mask;
  assign matched = pop12(sweep.ent.mask & rot_p);
  assign tsz     = pop12(sweep.ent.mask);
  assign ex_p    = nz && (sweep.ent.mask == rot_p);
  assign ex_u    = nz && (sweep.ent.mask == rot_u);
  assign part_ok = nz && (matched >= PC_W'(3)) &&
                   ({1'b0, matched} + 5'd1 >= {1'b0, tsz});

  // score = prio*10 - 25*missing classes + 50 on the bass root
  assign miss    = ctx.sz - matched;
  assign p12     = {5'b0, sweep.ent.prio};
  assign m12     = {8'b0, miss};
  assign score_u = (p12 << 3) + (p12 << 1) - ((m12 << 4) + (m12 << 3) + m12) +
                   ((ctx.bpc == PC_W'(ROOT)) ? 12'd50 : 12'd0);
  assign score   = score_t'(score_u);

  // Keep the first exact hits and the first strictly best partial score
  always_comb begin
    res_nxt = res_r;
    if (sweep.clr) begin
      res_nxt.xp_hit = 1'b0;
      res_nxt.xu_hit = 1'b0;
      res_nxt.pa_hit = 1'b0;
    end else if (sweep.vld) begin
      if (!res_r.xp_hit && ex_p) begin
        res_nxt.xp_hit = 1'b1;
        res_nxt.xp_t   = sweep.tidx;
      end
      if (!res_r.xu_hit && ex_u) begin
        res_nxt.xu_hit = 1'b1;
        res_nxt.xu_t   = sweep.tidx;
      end
      if (part_ok && (!res_r.pa_hit || (score > res_r.pa_score))) begin
        res_nxt.pa_hit   = 1'b1;
        res_nxt.pa_t     = sweep.tidx;
        res_nxt.pa_score = score;
      end
    end
  end

  // Hit flags reset; indexes and score only matter behind a hit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r.xp_hit   <= 1'b0;
      res_r.xu_hit   <= 1'b0;
      res_r.pa_hit   <= 1'b0;
      res_r.xp_t     <= res_nxt.xp_t;
      res_r.xu_t     <= res_nxt.xu_t;
      res_r.pa_t     <= res_nxt.pa_t;
      res_r.pa_score <= res_nxt.pa_score;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

### hw/rtl/chord_template_classifier.sv
`timescale 1ns / 1ps
// Chord template classifier top level: note scan, template sweep, lane walk.
// Depends on ctc_pkg, ctc_if, ctc_ram and ctc_lane.
//
//  channel   | dir | transfer payload
//  ----------+-----+---------------------------------------------------------
//  in_chan   | in  | notes_low[63:0], notes_high[63:0]
//  out_chan  | out | quality, root_class, bass_note, is_slash, tone_mask,
//            |     | decided_by
//
// After reset the template RAM is loaded from the package table, one entry a
// cycle; no input is taken meanwhile. For each item the note scan covers
// 8 notes a cycle and the sweep reads one template a cycle from the RAM,
// tested against all 12 roots at once. A finished result sits in the output
// register; the next item is taken while it waits, and only the final load
// stalls on out_chan.ready.

module chord_template_classifier #(
  parameter int TEMPLATE_COUNT = ctc_pkg::TEMPLATE_COUNT_DEF,
  parameter int NOTE_RANGE     = ctc_pkg::NOTE_RANGE_DEF
) (
  input logic      clk,
  input logic      rst_n,
  ctc_in_if.sink   in_chan,
  ctc_out_if.source out_chan
);
  import ctc_pkg::*;

  localparam int AW         = (TEMPLATE_COUNT > 1) ? $clog2(TEMPLATE_COUNT) : 1;
  localparam int SCAN_STEPS = (NOTE_RANGE + 7) / 8;

  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_PREP   = 3'd3;
  localparam logic [2:0] S_SWEEP  = 3'd4;
  localparam logic [2:0] S_TAIL   = 3'd5;
  localparam logic [2:0] S_WALK   = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  localparam logic [TPL_IDX_W-1:0] T_LAST    = TPL_IDX_W'(TEMPLATE_COUNT - 1);
  localparam logic [CHUNK_W-1:0]   C_LAST    = CHUNK_W'(SCAN_STEPS - 1);
  localparam logic [PC_W-1:0]      LANE_LAST = PC_W'(PC_N - 1);

  // Control state
  logic [2:0]           state_r, state_nxt;
  logic [TPL_IDX_W-1:0] fill_idx_r, fill_idx_nxt;
  logic [CHUNK_W-1:0]   chunk_r, chunk_nxt;
  logic [TPL_IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [TPL_IDX_W-1:0] rd_t_r, rd_t_nxt;
  logic [PC_W-1:0]      walk_r, walk_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Item data
  logic [127:0]    notes_sh_r, notes_sh_nxt;
  logic [PC_W-1:0] pc_base_r, pc_base_nxt;
  logic [11:0]     pcs_r, pcs_nxt;
  logic [1:0]      count_r, count_nxt;
  logic [6:0]      bass_r, bass_nxt;
  logic [PC_W-1:0] bpc_r, bpc_nxt;
  logic [11:0]     upper_r, upper_nxt;
  logic [PC_W-1:0] sz_r, sz_nxt;
  logic            up_ok_r, up_ok_nxt;

  // Walk results
  logic                 root_hit_r, root_hit_nxt;
  logic [TPL_IDX_W-1:0] root_t_r, root_t_nxt;
  logic                 up_hit_r, up_hit_nxt;
  logic [PC_W-1:0]      up_root_r, up_root_nxt;
  logic [TPL_IDX_W-1:0] up_t_r, up_t_nxt;
  logic                 inv_hit_r, inv_hit_nxt;
  logic [PC_W-1:0]      inv_root_r, inv_root_nxt;
  logic [TPL_IDX_W-1:0] inv_t_r, inv_t_nxt;
  logic                 pb_hit_r, pb_hit_nxt;
  logic [PC_W-1:0]      pb_root_r, pb_root_nxt;
  logic [TPL_IDX_W-1:0] pb_t_r, pb_t_nxt;
  score_t               pb_score_r, pb_score_nxt;

  // Output register
  logic [4:0]  out_quality_r, out_quality_nxt;
  logic [3:0]  out_root_r, out_root_nxt;
  logic [6:0]  out_bass_r, out_bass_nxt;
  logic        out_slash_r, out_slash_nxt;
  logic [11:0] out_mask_r, out_mask_nxt;
  logic [2:0]  out_dec_r, out_dec_nxt;

  logic            accept;
  logic            ram_we;
  tpl_entry_t      ram_wdata;
  logic [$bits(tpl_entry_t)-1:0] ram_rdata;
  sweep_t          sweep;
  ctx_t            ctx;
  lane_res_t       lres [PC_N];
  lane_res_t       cur;
  logic [PC_W-1:0] p7;
  logic            power_ok;

  assign accept        = (state_r == S_IDLE) && in_chan.valid;
  assign in_chan.ready = (state_r == S_IDLE);

  // Template RAM, filled once after reset
  assign ram_we    = (state_r == S_INIT);
  assign ram_wdata = '{mask: TPL_MASK[fill_idx_r], prio: TPL_PRIO[fill_idx_r]};

  ctc_ram #(
    .WIDTH($bits(tpl_entry_t)),
    .DEPTH(TEMPLATE_COUNT)
  ) u_tpl_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_idx_r[AW-1:0]),
    .wdata(ram_wdata),
    .raddr(rd_idx_r[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Template stream and item context into the lanes
  assign sweep.clr  = accept;
  assign sweep.vld  = rd_vld_r;
  assign sweep.tidx = rd_t_r;
  assign sweep.ent  = tpl_entry_t'(ram_rdata);
  assign ctx.pcs    = pcs_r;
  assign ctx.upper  = upper_r;
  assign ctx.sz     = sz_r;
  assign ctx.bpc    = bpc_r;

  for (genvar g = 0; g < PC_N; g++) begin : g_lane
    ctc_lane #(.ROOT(g)) u_lane (
      .clk  (clk),
      .rst_n(rst_n),
      .sweep(sweep),
      .ctx  (ctx),
      .res  (lres[g])
    );
  end

  assign cur = lres[walk_r];

  // Power chord check: exactly two classes, one of them the fifth above the bass class
  always_comb begin
    logic [4:0] s;
    s  = {1'b0, bpc_r} + 5'd7;
    p7 = (s >= 5'd12) ? PC_W'(s - 5'd12) : PC_W'(s);
  end
  assign power_ok = (pop12(pcs_r) == PC_W'(2)) && pcs_r[p7];

  // Sequencer
  always_comb begin
    logic [6:0] n_j;
    logic [4:0] pc_s;
    logic [4:0] pb_s;

    state_nxt     = state_r;
    fill_idx_nxt  = fill_idx_r;
    chunk_nxt     = chunk_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = 1'b0;
    rd_t_nxt      = rd_t_r;
    walk_nxt      = walk_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    notes_sh_nxt = notes_sh_r;
    pc_base_nxt  = pc_base_r;
    pcs_nxt      = pcs_r;
    count_nxt    = count_r;
    bass_nxt     = bass_r;
    bpc_nxt      = bpc_r;
    upper_nxt    = upper_r;
    sz_nxt       = sz_r;
    up_ok_nxt    = up_ok_r;

    root_hit_nxt = root_hit_r;
    root_t_nxt   = root_t_r;
    up_hit_nxt   = up_hit_r;
    up_root_nxt  = up_root_r;
    up_t_nxt     = up_t_r;
    inv_hit_nxt  = inv_hit_r;
    inv_root_nxt = inv_root_r;
    inv_t_nxt    = inv_t_r;
    pb_hit_nxt   = pb_hit_r;
    pb_root_nxt  = pb_root_r;
    pb_t_nxt     = pb_t_r;
    pb_score_nxt = pb_score_r;

    out_quality_nxt = out_quality_r;
    out_root_nxt    = out_root_r;
    out_bass_nxt    = out_bass_r;
    out_slash_nxt   = out_slash_r;
    out_mask_nxt    = out_mask_r;
    out_dec_nxt     = out_dec_r;

    n_j  = '0;
    pc_s = '0;
    pb_s = '0;

    case (state_r)
      S_INIT: begin
        fill_idx_nxt = fill_idx_r + 1'b1;
        if (fill_idx_r == T_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_chan.valid) begin
          notes_sh_nxt = {in_chan.notes_high, in_chan.notes_low};
          chunk_nxt    = '0;
          pc_base_nxt  = '0;
          pcs_nxt      = '0;
          count_nxt    = '0;
          bass_nxt     = '0;
          bpc_nxt      = '0;
          state_nxt    = S_SCAN;
        end
      end

      // Eight notes a cycle: fold to classes, find the bass, count to two
      S_SCAN: begin
        for (int j = 0; j < 8; j++) begin
          n_j  = {chunk_r, 3'b000} + 7'(j);
          pc_s = {1'b0, pc_base_r} + 5'(j);
          if (pc_s >= 5'd12) begin
            pc_s = pc_s - 5'd12;
          end
          if (notes_sh_r[j] && ({1'b0, n_j} < 8'(NOTE_RANGE))) begin
            pcs_nxt[PC_W'(pc_s)] = 1'b1;
            if (count_nxt == 2'd0) begin
              bass_nxt = n_j;
              bpc_nxt  = PC_W'(pc_s);
            end
            if (count_nxt != 2'd2) begin
              count_nxt = count_nxt + 2'd1;
            end
          end
        end
        notes_sh_nxt = notes_sh_r >> 8;
        chunk_nxt    = chunk_r + 1'b1;
        pb_s         = {1'b0, pc_base_r} + 5'd8;
        pc_base_nxt  = (pb_s >= 5'd12) ? PC_W'(pb_s - 5'd12) : PC_W'(pb_s);
        if (chunk_r == C_LAST) begin
          state_nxt = S_PREP;
        end
      end

      S_PREP: begin
        upper_nxt    = pcs_r & ~(12'd1 << bpc_r);
        sz_nxt       = pop12(pcs_r);
        up_ok_nxt    = pop12(pcs_r & ~(12'd1 << bpc_r)) >= PC_W'(3);
        rd_idx_nxt   = '0;
        walk_nxt     = '0;
        root_hit_nxt = 1'b0;
        up_hit_nxt   = 1'b0;
        inv_hit_nxt  = 1'b0;
        pb_hit_nxt   = 1'b0;
        state_nxt    = S_SWEEP;
      end

      // One template read a cycle; the lanes see it in the cycle after
      S_SWEEP: begin
        rd_vld_nxt = 1'b1;
        rd_t_nxt   = rd_idx_r;
        rd_idx_nxt = rd_idx_r + 1'b1;
        if (rd_idx_r == T_LAST) begin
          state_nxt = S_TAIL;
        end
      end

      S_TAIL: begin
        state_nxt = S_WALK;
      end

      // Visit the lanes in ascending root order
      S_WALK: begin
        if (walk_r == bpc_r) begin
          root_hit_nxt = cur.xp_hit;
          root_t_nxt   = cur.xp_t;
        end
        if (!up_hit_r && up_ok_r && upper_r[walk_r] && cur.xu_hit) begin
          up_hit_nxt  = 1'b1;
          up_root_nxt = walk_r;
          up_t_nxt    = cur.xu_t;
        end
        if (!inv_hit_r && pcs_r[walk_r] && (walk_r != bpc_r) && cur.xp_hit) begin
          inv_hit_nxt  = 1'b1;
          inv_root_nxt = walk_r;
          inv_t_nxt    = cur.xp_t;
        end
        if (pcs_r[walk_r] && cur.pa_hit && (!pb_hit_r || (cur.pa_score > pb_score_r))) begin
          pb_hit_nxt   = 1'b1;
          pb_root_nxt  = walk_r;
          pb_t_nxt     = cur.pa_t;
          pb_score_nxt = cur.pa_score;
        end
        walk_nxt = walk_r + 1'b1;
        if (walk_r == LANE_LAST) begin
          state_nxt = S_FINISH;
        end
      end

      // Pick the deciding stage and load the output register
      S_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_bass_nxt  = bass_r;
          out_root_nxt  = bpc_r;
          out_slash_nxt = 1'b0;
          if (count_r == 2'd0) begin
            out_quality_nxt = Q_UNKNOWN;
            out_mask_nxt    = '0;
            out_dec_nxt     = DEC_EMPTY;
          end else if (count_r == 2'd1) begin
            out_quality_nxt = Q_SINGLE;
            out_mask_nxt    = MASK_SINGLE;
            out_dec_nxt     = DEC_SINGLE;
          end else if (root_hit_r) begin
            out_quality_nxt = Q_BASE + root_t_r;
            out_mask_nxt    = TPL_MASK[root_t_r];
            out_dec_nxt     = DEC_ROOT;
          end else if (up_hit_r) begin
            out_quality_nxt = Q_BASE + up_t_r;
            out_root_nxt    = up_root_r;
            out_slash_nxt   = 1'b1;
            out_mask_nxt    = TPL_MASK[up_t_r];
            out_dec_nxt     = DEC_UPPER;
          end else if (inv_hit_r) begin
            out_quality_nxt = Q_BASE + inv_t_r;
            out_root_nxt    = inv_root_r;
            out_slash_nxt   = 1'b1;
            out_mask_nxt    = TPL_MASK[inv_t_r];
            out_dec_nxt     = DEC_INVERSION;
          end else if (pb_hit_r) begin
            out_quality_nxt = Q_BASE + pb_t_r;
            out_root_nxt    = pb_root_r;
            out_slash_nxt   = (pb_root_r != bpc_r);
            out_mask_nxt    = TPL_MASK[pb_t_r];
            out_dec_nxt     = DEC_PARTIAL;
          end else if (power_ok) begin
            out_quality_nxt = Q_POWER;
            out_mask_nxt    = MASK_POWER;
            out_dec_nxt     = DEC_POWER;
          end else begin
            out_quality_nxt = Q_CLUSTER;
            out_mask_nxt    = '0;
            out_dec_nxt     = DEC_CLUSTER;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      fill_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_idx_r  <= fill_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    chunk_r       <= chunk_nxt;
    rd_idx_r      <= rd_idx_nxt;
    rd_t_r        <= rd_t_nxt;
    walk_r        <= walk_nxt;
    notes_sh_r    <= notes_sh_nxt;
    pc_base_r     <= pc_base_nxt;
    pcs_r         <= pcs_nxt;
    count_r       <= count_nxt;
    bass_r        <= bass_nxt;
    bpc_r         <= bpc_nxt;
    upper_r       <= upper_nxt;
    sz_r          <= sz_nxt;
    up_ok_r       <= up_ok_nxt;
    root_hit_r    <= root_hit_nxt;
    root_t_r      <= root_t_nxt;
    up_hit_r      <= up_hit_nxt;
    up_root_r     <= up_root_nxt;
    up_t_r        <= up_t_nxt;
    inv_hit_r     <= inv_hit_nxt;
    inv_root_r    <= inv_root_nxt;
    inv_t_r       <= inv_t_nxt;
    pb_hit_r      <= pb_hit_nxt;
    pb_root_r     <= pb_root_nxt;
    pb_t_r        <= pb_t_nxt;
    pb_score_r    <= pb_score_nxt;
    out_quality_r <= out_quality_nxt;
    out_root_r    <= out_root_nxt;
    out_bass_r    <= out_bass_nxt;
    out_slash_r   <= out_slash_nxt;
    out_mask_r    <= out_mask_nxt;
    out_dec_r     <= out_dec_nxt;
  end

  // Result channel
  assign out_chan.valid      = out_valid_r;
  assign out_chan.quality    = out_quality_r;
  assign out_chan.root_class = out_root_r;
  assign out_chan.bass_note  = out_bass_r;
  assign out_chan.is_slash   = out_slash_r;
  assign out_chan.tone_mask  = out_mask_r;
  assign out_chan.decided_by = out_dec_r;

endmodule
